// ===== rtl/mscd_pkg.sv =====
// Shared types, opcode and event codes, and the command length table for the
// music sequence command decoder. No dependencies.
`default_nettype none

package mscd_pkg;

	// Opcodes with a meaning of their own.
	localparam logic [7:0] OP_OCT_FIRST  = 8'hD0;
	localparam logic [7:0] OP_OCT_LAST   = 8'hD6;
	localparam logic [7:0] OP_REPEAT     = 8'hED;
	localparam logic [7:0] OP_BREAK      = 8'hEE;
	localparam logic [7:0] OP_REPEAT_END = 8'hEF;
	localparam logic [7:0] OP_JUMP       = 8'hFC;

	localparam logic [3:0] KEY_REST      = 4'd12;
	localparam logic [6:0] OCTAVE_SEMIS  = 7'd12;
	localparam logic [15:0] FLOW_BIAS    = 16'd3;
	localparam logic [8:0] REPEAT_MAX    = 9'd256;
	localparam logic [3:0] CMD_SIZE_MAX  = 4'd10;

	localparam int NUM_LEN_SLOTS = 7;

	// Event kinds.
	localparam logic [2:0] KIND_NOTE    = 3'd0;
	localparam logic [2:0] KIND_TIE     = 3'd1;
	localparam logic [2:0] KIND_REST    = 3'd2;
	localparam logic [2:0] KIND_COMMAND = 3'd3;
	localparam logic [2:0] KIND_END     = 3'd4;

	// Flow kinds.
	localparam logic [2:0] FLOW_NONE       = 3'd0;
	localparam logic [2:0] FLOW_REPEAT     = 3'd1;
	localparam logic [2:0] FLOW_BREAK      = 3'd2;
	localparam logic [2:0] FLOW_REPEAT_END = 3'd3;
	localparam logic [2:0] FLOW_JUMP       = 3'd4;
	localparam logic [2:0] FLOW_END        = 3'd5;

	// Total command length for opcodes D0 to FC.
	localparam logic [3:0] CMD_LEN [0:44] = '{
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd4, 4'd2, 4'd4,
		4'd2, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
		4'd1, 4'd1, 4'd4, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd2, 4'd3, 4'd2,
		4'd2, 4'd2, 4'd2, 4'd4, 4'd2, 4'd3, 4'd10, 4'd2, 4'd3
	};

	typedef logic [NUM_LEN_SLOTS-1:0][7:0] len_slots_t;

	// Kept voice state: octave, last pitch played and the slur flag.
	typedef struct packed {
		logic [2:0] octave;
		logic [6:0] last_pitch;
		logic       slur;
	} voice_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [6:0]  pitch;
		logic [7:0]  duration;
		logic [7:0]  opcode;
		logic [3:0]  cmd_size;
		logic [7:0]  param_first;
		logic [7:0]  param_second;
		logic [2:0]  flow_kind;
		logic [15:0] flow_target;
		logic [8:0]  repeat_count;
		logic [15:0] cmd_addr;
	} event_t;

	function automatic logic [3:0] size_of(input logic [7:0] b);
		logic [5:0] idx;
		logic [3:0] size;
		idx = 6'(b - OP_OCT_FIRST);
		if (b < OP_OCT_FIRST)
			size = (b[2:0] != 3'd0) ? 4'd1 : 4'd2;
		else if (b > OP_JUMP)
			size = 4'd1;
		else
			size = CMD_LEN[idx];
		return size;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mscd_event.sv =====
// Decodes one fully assembled command into an event and the next voice state.
// Depends on mscd_pkg.
`default_nettype none

module mscd_event
	import mscd_pkg::*;
(
	input  wire logic [7:0]  opcode,
	input  wire logic [15:0] cmd_addr,
	input  wire logic [7:0]  param_first,
	input  wire logic [7:0]  param_second,
	input  wire logic [3:0]  cmd_size,
	input  wire voice_t      voice,
	input  wire len_slots_t  len_slots,
	output event_t           evt,
	output voice_t           voice_next
);

	logic [3:0]  key;
	logic [2:0]  len_idx;
	logic [2:0]  slot_idx;
	logic [6:0]  note_pitch;
	logic [15:0] offset;
	logic [15:0] rel_target;

	assign key        = opcode[7:4];
	assign len_idx    = opcode[2:0];
	assign slot_idx   = len_idx - 3'd1;
	assign note_pitch = 7'({4'd0, voice.octave} * OCTAVE_SEMIS) + {3'd0, key} + OCTAVE_SEMIS;
	assign offset     = {param_second, param_first};
	assign rel_target = cmd_addr + FLOW_BIAS + offset;

	always_comb begin
		evt              = '0;
		evt.event_kind   = KIND_COMMAND;
		evt.opcode       = opcode;
		evt.cmd_size     = cmd_size;
		evt.param_first  = param_first;
		evt.param_second = param_second;
		evt.cmd_addr     = cmd_addr;
		voice_next       = voice;

		if (opcode < OP_OCT_FIRST) begin
			evt.duration = (len_idx != 3'd0) ? len_slots[slot_idx] : param_first;
			if (key == KEY_REST) begin
				evt.event_kind  = KIND_REST;
				voice_next.slur = 1'b0;
			end else begin
				// A slurred repeat of the same pitch becomes a tie.
				evt.event_kind        = (voice.slur && note_pitch == voice.last_pitch) ?
					KIND_TIE : KIND_NOTE;
				evt.pitch             = note_pitch;
				voice_next.last_pitch = note_pitch;
				voice_next.slur       = opcode[3];
			end
		end else if (opcode <= OP_OCT_LAST) begin
			voice_next.octave = opcode[2:0];
		end else begin
			case (opcode)
				OP_REPEAT: begin
					evt.flow_kind    = FLOW_REPEAT;
					evt.repeat_count = (param_first != 8'd0) ? {1'b0, param_first} : REPEAT_MAX;
				end
				OP_BREAK: begin
					evt.flow_kind   = FLOW_BREAK;
					evt.flow_target = rel_target;
				end
				OP_REPEAT_END: begin
					evt.flow_kind = FLOW_REPEAT_END;
				end
				OP_JUMP: begin
					if (offset == 16'd0) begin
						evt.flow_kind  = FLOW_END;
						evt.event_kind = KIND_END;
					end else begin
						evt.flow_kind   = FLOW_JUMP;
						evt.flow_target = rel_target;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/music_sequence_command_decoder.sv =====
// Top level of the music sequence command decoder: input register, command
// assembly state, event register. Depends on mscd_pkg and mscd_event.
`default_nettype none

// The decoder takes a sequence track one byte per request, with its address and
// a track-begin flag, and delivers one decoded event for every completed command
// (note, tie, rest, command or end of track). A byte is registered on arrival;
// when it leaves the input register it updates the command assembly state and,
// if it completes a command, its event is written into the output register.
// The block sustains one byte per cycle unless a completing byte meets a stalled,
// full event register, and a command's event reaches the outputs through the
// input register and the event register, which holds it until it is taken. The
// output register is freed in the same cycle it is taken, so a stall on the
// event side only holds back the byte side when a waiting byte completes a
// command and the event register is still occupied. Bytes that do not complete
// a command never wait. The seven note length registers are written through the
// configuration channel, which is always ready; indices beyond the seventh
// register are ignored. They should be written only while no byte is in flight.
module music_sequence_command_decoder
	import mscd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Byte channel.
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic [15:0] byte_addr,
	input  wire logic        track_begin,
	// Event channel.
	output logic             event_valid,
	input  wire logic        event_stall,
	output logic [2:0]       event_kind,
	output logic [6:0]       pitch,
	output logic [7:0]       duration,
	output logic [7:0]       opcode,
	output logic [3:0]       cmd_size,
	output logic [7:0]       param_first,
	output logic [7:0]       param_second,
	output logic [2:0]       flow_kind,
	output logic [15:0]      flow_target,
	output logic [8:0]       repeat_count,
	output logic [15:0]      cmd_addr,
	// Configuration channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	// Input register.
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic [15:0] addr_s1;
	logic        begin_s1;

	// Command assembly and voice state.
	logic [3:0]  bytes_left_q;
	logic [7:0]  held_opcode_q;
	logic [15:0] held_addr_q;
	logic [7:0]  held_p0_q;
	logic [7:0]  held_p1_q;
	logic [3:0]  held_size_q;
	voice_t      voice_q;
	len_slots_t  len_slots_q;

	// Event register.
	logic        event_valid_q;
	event_t      event_q;

	// Next-state values for the byte in the input register.
	logic [3:0]  bytes_left_cur;
	logic [3:0]  bytes_left_nxt;
	logic [7:0]  opcode_nxt;
	logic [15:0] addr_nxt;
	logic [7:0]  p0_nxt;
	logic [7:0]  p1_nxt;
	logic [3:0]  size_nxt;
	logic [3:0]  pos;
	logic        completes;
	voice_t      voice_cur;
	voice_t      voice_emit;
	event_t      evt;
	logic        advance_s1;
	logic        accept_byte;

	// A track begin clears the voice and drops any partial command before the
	// byte is looked at.
	assign voice_cur      = begin_s1 ? '0 : voice_q;
	assign bytes_left_cur = begin_s1 ? 4'd0 : bytes_left_q;
	assign pos            = held_size_q - bytes_left_cur;

	always_comb begin
		opcode_nxt     = held_opcode_q;
		addr_nxt       = held_addr_q;
		p0_nxt         = held_p0_q;
		p1_nxt         = held_p1_q;
		size_nxt       = held_size_q;
		bytes_left_nxt = bytes_left_cur;
		completes      = 1'b0;
		if (bytes_left_cur == 4'd0) begin
			// First byte of a new command.
			opcode_nxt = data_s1;
			addr_nxt   = addr_s1;
			p0_nxt     = 8'd0;
			p1_nxt     = 8'd0;
			size_nxt   = size_of(data_s1);
			if (size_nxt == 4'd1)
				completes = 1'b1;
			else
				bytes_left_nxt = size_nxt - 4'd1;
		end else begin
			// Parameter bytes; only the first two are kept.
			if (pos == 4'd1)
				p0_nxt = data_s1;
			else if (pos == 4'd2)
				p1_nxt = data_s1;
			bytes_left_nxt = bytes_left_cur - 4'd1;
			completes      = (bytes_left_nxt == 4'd0);
		end
	end

	mscd_event u_event (
		.opcode       (opcode_nxt),
		.cmd_addr     (addr_nxt),
		.param_first  (p0_nxt),
		.param_second (p1_nxt),
		.cmd_size     (size_nxt),
		.voice        (voice_cur),
		.len_slots    (len_slots_q),
		.evt          (evt),
		.voice_next   (voice_emit)
	);

	// The held byte may move on unless it completes a command and the event
	// register is full and not being taken.
	assign advance_s1  = valid_s1 && (!completes || !event_valid_q || !event_stall);
	assign byte_stall  = valid_s1 && !advance_s1;
	assign accept_byte = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_byte) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_byte) begin
			data_s1  <= data_byte;
			addr_s1  <= byte_addr;
			begin_s1 <= track_begin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q  <= '0;
			held_opcode_q <= '0;
			held_addr_q   <= '0;
			held_p0_q     <= '0;
			held_p1_q     <= '0;
			held_size_q   <= '0;
			voice_q       <= '0;
		end else if (advance_s1) begin
			bytes_left_q  <= bytes_left_nxt;
			held_opcode_q <= opcode_nxt;
			held_addr_q   <= addr_nxt;
			held_p0_q     <= p0_nxt;
			held_p1_q     <= p1_nxt;
			held_size_q   <= size_nxt;
			voice_q       <= completes ? voice_emit : voice_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_valid_q <= 1'b0;
		end else if (advance_s1 && completes) begin
			event_valid_q <= 1'b1;
		end else if (!event_stall) begin
			event_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && completes)
			event_q <= evt;
	end

	// Length registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_slots_q <= '0;
		end else if (cfg_valid && cfg_ready && cfg_index < 3'(NUM_LEN_SLOTS)) begin
			len_slots_q[cfg_index] <= cfg_data;
		end
	end

	assign event_valid  = event_valid_q;
	assign event_kind   = event_q.event_kind;
	assign pitch        = event_q.pitch;
	assign duration     = event_q.duration;
	assign opcode       = event_q.opcode;
	assign cmd_size     = event_q.cmd_size;
	assign param_first  = event_q.param_first;
	assign param_second = event_q.param_second;
	assign flow_kind    = event_q.flow_kind;
	assign flow_target  = event_q.flow_target;
	assign repeat_count = event_q.repeat_count;
	assign cmd_addr     = event_q.cmd_addr;

`ifndef NO_ASSERTIONS
	// A command in progress always has fewer bytes still to come than its size.
	a_bytes_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_left_q != 4'd0 |-> bytes_left_q < held_size_q)
		else $error("bytes_left exceeds the held command size");

	// A delivered event covers between one and ten bytes.
	a_event_size: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid_q |-> event_q.cmd_size != 4'd0 && event_q.cmd_size <= CMD_SIZE_MAX)
		else $error("event carries an impossible command size");

	// End of track comes only from a jump with no offset.
	a_end_is_jump: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid_q && event_q.event_kind == KIND_END |->
		event_q.flow_kind == FLOW_END && event_q.opcode == OP_JUMP)
		else $error("end of track event not from a zero jump");

	// The byte side is held back only while a byte waits in the input register.
	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && event_valid_q)
		else $error("byte side stalled with nothing waiting");

	// A completed byte that finds the event register busy keeps the register full.
	a_event_kept: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && completes |=> event_valid_q)
		else $error("completed command lost its event");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_music_sequence_command_decoder.sv =====
// Self-checking testbench for music_sequence_command_decoder: drives byte requests and length
// register writes, and checks every decoded event against a predictor held in this file.
// Depends on mscd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_music_sequence_command_decoder;
	import mscd_pkg::*;

	// Length register indexes on the configuration channel. The eighth index has no register
	// behind it and must be ignored by the block.
	localparam logic [2:0] REG_LEN_ONE   = 3'd0;
	localparam logic [2:0] REG_LEN_SEVEN = 3'd6;
	localparam logic [2:0] REG_SPARE     = 3'd7;

	// A command's event reaches the outputs through the input register and the event register,
	// so once the last event due is taken, this settle time leaves nothing in flight.
	localparam int SETTLE_CYCLES = 6;
	// Longest correct stretch without any request taken is a sender gap on top of a receiver
	// stall; this limit is many times that.
	localparam int STILL_LIMIT = 1000;
	// Bytes of random track per phase.
	localparam int PHASE_BYTES = 256;

	typedef enum {LEN_ZERO, LEN_FULL, LEN_SPREAD, LEN_RANDOM} len_fill_e;

	// Predictor of the decoder: it keeps its own copy of the assembly state, the voice state
	// and the length registers, and queues the event that each completed command yields.
	class track_event_board;
		logic [7:0]  len_slot [NUM_LEN_SLOTS];
		logic [3:0]  bytes_left;
		logic [7:0]  held_opcode;
		logic [15:0] held_addr;
		logic [7:0]  held_param [2];
		logic [3:0]  held_size;
		logic [2:0]  octave;
		logic [6:0]  last_pitch;
		logic        slur;
		event_t      due_events [$];
		int unsigned error_count;

		function new();
			foreach (len_slot[i]) len_slot[i] = '0;
			bytes_left = '0;
			held_opcode = '0;
			held_addr = '0;
			held_param[0] = '0;
			held_param[1] = '0;
			held_size = '0;
			octave = '0;
			last_pitch = '0;
			slur = 1'b0;
			error_count = 0;
		endfunction

		// Total bytes of the command that starts with this byte.
		static function logic [3:0] command_length(input logic [7:0] code);
			logic [3:0] size;
			if (code < OP_OCT_FIRST) begin
				size = (code[2:0] != 3'd0) ? 4'd1 : 4'd2;
			end else begin
				case (code)
					8'hD9, 8'hDB, 8'hEA, 8'hF0, 8'hF7: size = 4'd4;
					OP_REPEAT, OP_BREAK, OP_REPEAT_END, 8'hF2, 8'hF9, OP_JUMP: size = 4'd3;
					8'hFA: size = 4'd10;
					8'hD7, 8'hD8, 8'hDA, 8'hDC, 8'hDD, 8'hDE, 8'hE7, 8'hEB, 8'hEC, 8'hF1, 8'hF3,
					8'hF4, 8'hF5, 8'hF6, 8'hF8, 8'hFB: size = 4'd2;
					default: size = 4'd1;
				endcase
			end
			return size;
		endfunction

		function void load_length(input logic [2:0] index, input logic [7:0] value);
			if (index < NUM_LEN_SLOTS) len_slot[index] = value;
		endfunction

		function int pending();
			return due_events.size();
		endfunction

		// Decodes the held command and queues its event, updating the voice state.
		function void finish_command();
			event_t ev;
			logic [3:0] key;
			logic [2:0] len_idx;
			logic [6:0] semis;
			logic [15:0] offset;
			logic [15:0] rel_target;
			ev = '0;
			ev.event_kind = KIND_COMMAND;
			ev.opcode = held_opcode;
			ev.cmd_size = held_size;
			ev.param_first = held_param[0];
			ev.param_second = held_param[1];
			ev.flow_kind = FLOW_NONE;
			ev.cmd_addr = held_addr;
			if (held_opcode < OP_OCT_FIRST) begin
				key = held_opcode[7:4];
				len_idx = held_opcode[2:0];
				ev.duration = (len_idx != 3'd0) ? len_slot[len_idx - 1] : held_param[0];
				if (key == KEY_REST) begin
					ev.event_kind = KIND_REST;
					slur = 1'b0;
				end else begin
					semis = 7'(octave) * OCTAVE_SEMIS + 7'(key) + OCTAVE_SEMIS;
					ev.event_kind = (slur && semis == last_pitch) ? KIND_TIE : KIND_NOTE;
					ev.pitch = semis;
					last_pitch = semis;
					slur = held_opcode[3];
				end
			end else if (held_opcode <= OP_OCT_LAST) begin
				octave = 3'(held_opcode - OP_OCT_FIRST);
			end else begin
				offset = {held_param[1], held_param[0]};
				rel_target = held_addr + FLOW_BIAS + offset;
				case (held_opcode)
					OP_REPEAT: begin
						ev.flow_kind = FLOW_REPEAT;
						ev.repeat_count = (held_param[0] == 8'd0) ? REPEAT_MAX : {1'b0, held_param[0]};
					end
					OP_BREAK: begin
						ev.flow_kind = FLOW_BREAK;
						ev.flow_target = rel_target;
					end
					OP_REPEAT_END: begin
						ev.flow_kind = FLOW_REPEAT_END;
					end
					OP_JUMP: begin
						if (offset == 16'd0) begin
							ev.flow_kind = FLOW_END;
							ev.event_kind = KIND_END;
						end else begin
							ev.flow_kind = FLOW_JUMP;
							ev.flow_target = rel_target;
						end
					end
					default: ;
				endcase
			end
			due_events = {due_events, ev};
		endfunction

		// Notes one accepted byte request.
		function void take_byte(input logic [7:0] value, input logic [15:0] addr,
				input logic begin_flag);
			logic [3:0] pos;
			if (begin_flag) begin
				octave = '0;
				last_pitch = '0;
				slur = 1'b0;
				bytes_left = '0;
			end
			if (bytes_left == 4'd0) begin
				held_opcode = value;
				held_addr = addr;
				held_param[0] = '0;
				held_param[1] = '0;
				held_size = command_length(value);
				if (held_size <= 4'd1) finish_command();
				else bytes_left = held_size - 4'd1;
			end else begin
				pos = held_size - bytes_left;
				if (pos == 4'd1) held_param[0] = value;
				else if (pos == 4'd2) held_param[1] = value;
				bytes_left = bytes_left - 4'd1;
				if (bytes_left == 4'd0) finish_command();
			end
		endfunction

		function void compare_field(input string field, input logic [15:0] want,
				input logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				error_count++;
			end
		endfunction

		// Checks one accepted event against the oldest one due.
		function void check_event(input event_t got);
			event_t want;
			if (due_events.size() == 0) begin
				$error("event with none due: opcode %0h at address %0h", got.opcode, got.cmd_addr);
				error_count++;
				return;
			end
			want = due_events.pop_front();
			compare_field("event_kind", want.event_kind, got.event_kind);
			compare_field("pitch", want.pitch, got.pitch);
			compare_field("duration", want.duration, got.duration);
			compare_field("opcode", want.opcode, got.opcode);
			compare_field("cmd_size", want.cmd_size, got.cmd_size);
			compare_field("param_first", want.param_first, got.param_first);
			compare_field("param_second", want.param_second, got.param_second);
			compare_field("flow_kind", want.flow_kind, got.flow_kind);
			compare_field("flow_target", want.flow_target, got.flow_target);
			compare_field("repeat_count", want.repeat_count, got.repeat_count);
			compare_field("cmd_addr", want.cmd_addr, got.cmd_addr);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  data_byte;
	logic [15:0] byte_addr;
	logic        track_begin;
	logic        event_valid;
	logic        event_stall;
	logic [2:0]  event_kind;
	logic [6:0]  pitch;
	logic [7:0]  duration;
	logic [7:0]  opcode;
	logic [3:0]  cmd_size;
	logic [7:0]  param_first;
	logic [7:0]  param_second;
	logic [2:0]  flow_kind;
	logic [15:0] flow_target;
	logic [8:0]  repeat_count;
	logic [15:0] cmd_addr;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;

	track_event_board board = new();

	// Stimulus controls. gap_odds of n gives the sender a gap before roughly one byte in n,
	// and zero turns gaps off; tail_calm turns off the event side's stalls for the last part of the run.
	logic [15:0] track_addr = '0;
	int unsigned gap_odds = 8;
	logic        tail_calm = 1'b0;
	logic        force_begin = 1'b0;
	logic [3:0]  prev_key = '0;
	int unsigned bytes_sent = 0;
	int unsigned still_cycles = 0;

	music_sequence_command_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.data_byte   (data_byte),
		.byte_addr   (byte_addr),
		.track_begin (track_begin),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_kind  (event_kind),
		.pitch       (pitch),
		.duration    (duration),
		.opcode      (opcode),
		.cmd_size    (cmd_size),
		.param_first (param_first),
		.param_second(param_second),
		.flow_kind   (flow_kind),
		.flow_target (flow_target),
		.repeat_count(repeat_count),
		.cmd_addr    (cmd_addr),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Everything is sampled at the rising edge, before the block's own registers move. A
	// register write and a byte request update the predictor; an event request is checked.
	// The watchdog counts edges at which no request of any kind is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) board.load_length(cfg_index, cfg_data);
			if (byte_valid && !byte_stall) board.take_byte(data_byte, byte_addr, track_begin);
			if (event_valid && !event_stall) begin
				board.check_event({event_kind, pitch, duration, opcode, cmd_size, param_first,
					param_second, flow_kind, flow_target, repeat_count, cmd_addr});
			end
			if ((cfg_valid && cfg_ready) || (byte_valid && !byte_stall) ||
					(event_valid && !event_stall))
				still_cycles = 0;
			else
				still_cycles++;
			if (still_cycles >= STILL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// The event side alternates free runs, now and then long ones, with stall bursts of random
	// length until tail_calm is set. Each falling edge carries at most one update of the stall.
	initial begin
		int unsigned run;
		event_stall = 1'b0;
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
			@(negedge clk);
			event_stall <= 1'b0;
			repeat (run - 1) @(negedge clk);
			if (!tail_calm) begin
				run = $urandom_range(1, 16);
				@(negedge clk);
				event_stall <= 1'b1;
				repeat (run - 1) @(negedge clk);
			end
		end
	end

	// Offers one byte at the running address and holds it until the request is taken. A
	// random gap may come first; valid stays high from one byte to the next otherwise.
	task automatic drive_byte(input logic [7:0] value, input logic begin_flag);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			@(negedge clk);
			byte_valid <= 1'b0;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
		@(negedge clk);
		byte_valid <= 1'b1;
		data_byte <= value;
		byte_addr <= track_addr;
		track_begin <= begin_flag;
		do @(posedge clk); while (byte_stall);
		track_addr = track_addr + 16'd1;
		bytes_sent++;
	endtask

	// Stops the byte side and waits until every event due has been taken, then lets the
	// block's pipeline run empty.
	task automatic settle();
		@(negedge clk);
		byte_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Writes all seven length registers back to back, then the unused index.
	task automatic load_lengths(input len_fill_e fill);
		logic [7:0] value;
		for (int i = REG_LEN_ONE; i <= REG_LEN_SEVEN; i++) begin
			case (fill)
				LEN_ZERO:   value = 8'h00;
				LEN_FULL:   value = 8'hFF;
				LEN_SPREAD: value = 8'(i * 37 + 5);
				default:    value = 8'($urandom);
			endcase
			write_reg(3'(i), value);
		end
		write_reg(REG_SPARE, 8'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A short hand-written track covering the extremes: explicit and register lengths, the
	// highest pitch, a slur into a tie, a rest, a repeat count of zero, a break whose target
	// wraps past the top of memory, a jump with no offset (end of track), an opcode above the
	// table, a track restart that drops a half-built command, and a jump back onto itself.
	task automatic directed_track();
		track_addr = 16'h0000;
		drive_byte(8'h00, 1'b1);
		drive_byte(8'hFF, 1'b0);
		drive_byte(OP_OCT_LAST, 1'b0);
		drive_byte(8'hBF, 1'b0);
		drive_byte(8'hB9, 1'b0);
		drive_byte(8'hC7, 1'b0);
		drive_byte(OP_OCT_FIRST, 1'b0);
		drive_byte(OP_REPEAT, 1'b0);
		drive_byte(8'h00, 1'b0);
		drive_byte(8'hFF, 1'b0);
		track_addr = 16'hFFFE;
		drive_byte(OP_BREAK, 1'b0);
		drive_byte(8'hFF, 1'b0);
		drive_byte(8'h7F, 1'b0);
		drive_byte(OP_REPEAT_END, 1'b0);
		drive_byte(8'h12, 1'b0);
		drive_byte(8'h34, 1'b0);
		drive_byte(OP_JUMP, 1'b0);
		drive_byte(8'h00, 1'b0);
		drive_byte(8'h00, 1'b0);
		drive_byte(8'hFF, 1'b0);
		drive_byte(OP_BREAK, 1'b0);
		drive_byte(8'h55, 1'b0);
		drive_byte(8'h01, 1'b1);
		drive_byte(OP_JUMP, 1'b0);
		drive_byte(8'hFD, 1'b0);
		drive_byte(8'hFF, 1'b0);
	endtask

	// One random command, mostly well formed: notes (often reusing the last key so that slurs
	// turn into ties), octave changes, flow commands with zero offsets now and then, the rest
	// of the table, opcodes above it, and some noise that is cut short and then abandoned by
	// a track restart on the next command.
	task automatic random_command();
		logic [7:0] op;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [3:0] size;
		logic begin_flag;
		int unsigned pick;
		int unsigned cut;
		pick = $urandom_range(0, 99);
		begin_flag = ($urandom_range(0, 59) == 0) || force_begin;
		if (begin_flag || $urandom_range(0, 39) == 0) track_addr = 16'($urandom);
		if (pick < 45) begin
			op = 8'($urandom_range(0, OP_OCT_FIRST - 1));
			if ($urandom_range(0, 2) == 0) op[7:4] = prev_key;
			prev_key = op[7:4];
		end else if (pick < 55) begin
			op = OP_OCT_FIRST + 8'($urandom_range(0, 6));
		end else if (pick < 65) begin
			case ($urandom_range(0, 3))
				0: op = OP_REPEAT;
				1: op = OP_BREAK;
				2: op = OP_REPEAT_END;
				default: op = OP_JUMP;
			endcase
		end else if (pick < 90) begin
			op = 8'($urandom_range(OP_OCT_LAST + 1, OP_JUMP));
		end else if (pick < 95) begin
			op = 8'($urandom_range(OP_JUMP + 1, 255));
		end else begin
			op = 8'($urandom);
		end
		size = track_event_board::command_length(op);
		lo = 8'($urandom);
		hi = 8'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			lo = 8'h00;
			hi = 8'h00;
		end
		cut = (pick >= 95 && size > 4'd1) ? $urandom_range(1, size - 1) : size;
		drive_byte(op, begin_flag);
		force_begin = 1'b0;
		for (int i = 1; i < cut; i++) begin
			if (i == 1) drive_byte(lo, 1'b0);
			else if (i == 2) drive_byte(hi, 1'b0);
			else drive_byte(8'($urandom), 1'b0);
		end
		if (cut < size) force_begin = 1'b1;
	endtask

	task automatic random_phase(input int unsigned count);
		int unsigned goal;
		goal = bytes_sent + count;
		while (bytes_sent < goal) random_command();
	endtask

	// Main sequence: reset, lengths, the directed track, then four random phases. Between
	// phases the sender waits for every event to come back before the registers change,
	// and the last phase runs without any idling on either side.
	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		data_byte = '0;
		byte_addr = '0;
		track_begin = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		load_lengths(LEN_SPREAD);
		directed_track();

		settle();
		load_lengths(LEN_FULL);
		gap_odds = 6;
		random_phase(PHASE_BYTES);

		settle();
		load_lengths(LEN_ZERO);
		gap_odds = 12;
		random_phase(PHASE_BYTES);

		settle();
		load_lengths(LEN_RANDOM);
		gap_odds = 4;
		random_phase(PHASE_BYTES);

		settle();
		load_lengths(LEN_RANDOM);
		gap_odds = 0;
		tail_calm = 1'b1;
		random_phase(PHASE_BYTES);

		settle();
		if (board.error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
